// ===== design/ssrc_pkg.sv =====
// Package for the shadow stack return checker: beat types, request codes
// and controller states. No dependencies.
`timescale 1ns / 1ps

package ssrc_pkg;

  localparam int SITE_W  = 64;
  localparam int INDEX_W = 6;
  localparam int OCNT_W  = 32;

  localparam logic [1:0] REQ_CALL = 2'd0;
  localparam logic [1:0] REQ_RET  = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;
  localparam logic [1:0] REQ_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [SITE_W-1:0]  site_address;
    logic [SITE_W-1:0]  return_target;
    logic [INDEX_W-1:0] entry_index;
  } in_t;

  typedef struct packed {
    logic               return_matched;
    logic [1:0]         match_depth;
    logic               stack_was_empty;
    logic               mismatch_flagged;
    logic [SITE_W-1:0]  report_site;
    logic [OCNT_W-1:0]  site_count;
    logic               entry_valid;
    logic               table_full;
    logic               stack_overflowed;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRD,
    ST_SCMP,
    ST_TRD,
    ST_TCMP,
    ST_RDAT,
    ST_RESP
  } state_t;

endpackage

// ===== design/ssrc_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the shadow stack and the site tag and count tables; no dependencies.
`timescale 1ns / 1ps

module ssrc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/shadow_stack_return_checker_top.sv =====
// Calls, empty returns, table read misses and idle requests go straight to the response
// state; a table read hit passes through a data state first. A return searches the stack
// one entry per read and compare step, up to the search depth, and on a miss scans the
// table one entry per step. A new request is taken only in idle, after the result is
// loaded into the output register. Synchronous active-low reset clears the state, output
// valid, stack pointer and fill counts; RAM contents stay undefined and no clearing pass runs.
`timescale 1ns / 1ps

module shadow_stack_return_checker_top #(
  parameter int STACK_DEPTH   = 64,
  parameter int SEARCH_DEPTH  = 4,
  parameter int TABLE_ENTRIES = 64,
  parameter int COUNT_WIDTH   = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ssrc_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ssrc_pkg::out_t out_data
);

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SFW = $clog2(STACK_DEPTH + 1);
  localparam int TAW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int TFW = $clog2(TABLE_ENTRIES + 1);
  localparam int KW  = $clog2(SEARCH_DEPTH) + 1;

  ssrc_pkg::state_t state_r, state_nxt;
  ssrc_pkg::in_t    req_r, req_nxt;
  ssrc_pkg::out_t   res_r, res_nxt;
  ssrc_pkg::out_t   out_data_r;
  logic             out_valid_r;
  logic             out_load;

  logic [SAW-1:0] top_r, top_nxt;
  logic [SFW-1:0] fill_r, fill_nxt;
  logic [TFW-1:0] tfill_r, tfill_nxt;
  logic [KW-1:0]  k_r, k_nxt;
  logic [TFW-1:0] j_r, j_nxt;

  logic                   stk_we;
  logic [SAW-1:0]         stk_raddr;
  logic [63:0]            stk_rdata;
  logic                   tag_we, cnt_we;
  logic [TAW-1:0]         tbl_waddr, tbl_raddr;
  logic [63:0]            tag_rdata;
  logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata, cnt_inc;
  logic [63:0]            cnt_ext;

  logic [KW-1:0] slot_k;
  logic [31:0]   slot_raw, slot_mod;
  logic [15:0]   k_plus, j_plus, idx_w;
  logic          search_more, scan_more;

  ssrc_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (top_r),
    .wdata (in_data.site_address),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  ssrc_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES)) u_tags (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tbl_waddr),
    .wdata (req_r.site_address),
    .raddr (tbl_raddr),
    .rdata (tag_rdata)
  );

  ssrc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(TABLE_ENTRIES)) u_counts (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (tbl_waddr),
    .wdata (cnt_wdata),
    .raddr (tbl_raddr),
    .rdata (cnt_rdata)
  );

  // Slot k entries below the top; the sum stays below twice the depth.
  always_comb begin
    slot_k   = (state_r == ssrc_pkg::ST_IDLE) ? '0 : k_r;
    slot_raw = 32'(top_r) + 32'(STACK_DEPTH) - 32'd1 - 32'(slot_k);
    slot_mod = (slot_raw >= 32'(STACK_DEPTH)) ? slot_raw - 32'(STACK_DEPTH) : slot_raw;
    stk_raddr = slot_mod[SAW-1:0];
  end

  assign idx_w     = 16'(in_data.entry_index);
  assign tbl_raddr = (state_r == ssrc_pkg::ST_IDLE) ? idx_w[TAW-1:0] : j_r[TAW-1:0];

  assign k_plus      = 16'(k_r) + 16'd1;
  assign j_plus      = 16'(j_r) + 16'd1;
  assign search_more = (k_plus < 16'(fill_r)) && (k_plus < 16'(SEARCH_DEPTH));
  assign scan_more   = j_plus < 16'(tfill_r);

  assign cnt_inc = (&cnt_rdata) ? cnt_rdata : cnt_rdata + COUNT_WIDTH'(1);

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    res_nxt   = res_r;
    top_nxt   = top_r;
    fill_nxt  = fill_r;
    tfill_nxt = tfill_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    stk_we    = 1'b0;
    tag_we    = 1'b0;
    cnt_we    = 1'b0;
    tbl_waddr = j_r[TAW-1:0];
    cnt_wdata = cnt_inc;
    cnt_ext   = 64'(cnt_inc);
    out_load  = 1'b0;

    case (state_r)
      ssrc_pkg::ST_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          res_nxt   = '0;
          k_nxt     = '0;
          j_nxt     = '0;
          state_nxt = ssrc_pkg::ST_RESP;
          case (in_data.req_type)
            ssrc_pkg::REQ_CALL: begin
              stk_we  = 1'b1;
              top_nxt = (32'(top_r) == 32'(STACK_DEPTH - 1)) ? '0 : top_r + SAW'(1);
              if (32'(fill_r) >= 32'(STACK_DEPTH)) begin
                res_nxt.stack_overflowed = 1'b1;
              end else begin
                fill_nxt = fill_r + SFW'(1);
              end
            end
            ssrc_pkg::REQ_RET: begin
              if (fill_r == '0) begin
                res_nxt.stack_was_empty = 1'b1;
              end else begin
                state_nxt = ssrc_pkg::ST_SCMP;
              end
            end
            ssrc_pkg::REQ_READ: begin
              if (32'(in_data.entry_index) < 32'(tfill_r)) begin
                state_nxt = ssrc_pkg::ST_RDAT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ssrc_pkg::ST_SRD: begin
        state_nxt = ssrc_pkg::ST_SCMP;
      end
      ssrc_pkg::ST_SCMP: begin
        if (stk_rdata == req_r.return_target) begin
          res_nxt.return_matched = 1'b1;
          res_nxt.match_depth    = k_plus[1:0] - 2'd1;
          top_nxt   = stk_raddr;
          fill_nxt  = fill_r - k_plus[SFW-1:0];
          state_nxt = ssrc_pkg::ST_RESP;
        end else if (search_more) begin
          k_nxt     = k_plus[KW-1:0];
          state_nxt = ssrc_pkg::ST_SRD;
        end else begin
          res_nxt.mismatch_flagged = 1'b1;
          res_nxt.report_site      = req_r.site_address;
          if (tfill_r == '0) begin
            // Empty table: record the site straight away.
            tag_we    = 1'b1;
            cnt_we    = 1'b1;
            tbl_waddr = '0;
            cnt_wdata = COUNT_WIDTH'(1);
            tfill_nxt = TFW'(1);
            res_nxt.site_count = ssrc_pkg::OCNT_W'(1);
            state_nxt = ssrc_pkg::ST_RESP;
          end else begin
            state_nxt = ssrc_pkg::ST_TRD;
          end
        end
      end
      ssrc_pkg::ST_TRD: begin
        state_nxt = ssrc_pkg::ST_TCMP;
      end
      ssrc_pkg::ST_TCMP: begin
        if (tag_rdata == req_r.site_address) begin
          cnt_we = 1'b1;
          res_nxt.site_count = cnt_ext[ssrc_pkg::OCNT_W-1:0];
          state_nxt = ssrc_pkg::ST_RESP;
        end else if (scan_more) begin
          j_nxt     = j_plus[TFW-1:0];
          state_nxt = ssrc_pkg::ST_TRD;
        end else begin
          state_nxt = ssrc_pkg::ST_RESP;
          if (32'(tfill_r) < 32'(TABLE_ENTRIES)) begin
            tag_we    = 1'b1;
            cnt_we    = 1'b1;
            tbl_waddr = tfill_r[TAW-1:0];
            cnt_wdata = COUNT_WIDTH'(1);
            tfill_nxt = tfill_r + TFW'(1);
            res_nxt.site_count = ssrc_pkg::OCNT_W'(1);
          end else begin
            res_nxt.table_full = 1'b1;
          end
        end
      end
      ssrc_pkg::ST_RDAT: begin
        cnt_ext = 64'(cnt_rdata);
        res_nxt.entry_valid = 1'b1;
        res_nxt.report_site = tag_rdata;
        res_nxt.site_count  = cnt_ext[ssrc_pkg::OCNT_W-1:0];
        state_nxt = ssrc_pkg::ST_RESP;
      end
      ssrc_pkg::ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ssrc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ssrc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssrc_pkg::ST_IDLE;
      top_r       <= '0;
      fill_r      <= '0;
      tfill_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      top_r   <= top_nxt;
      fill_r  <= fill_nxt;
      tfill_r <= tfill_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    res_r <= res_nxt;
    k_r   <= k_nxt;
    j_r   <= j_nxt;
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  assign in_ready  = (state_r == ssrc_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // A new result beat is only ever launched from the response state.
  a_launch_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ssrc_pkg::ST_RESP))
    else $error("result beat launched outside the response state");

  // An accepted request always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != ssrc_pkg::ST_IDLE))
    else $error("accepted request did not start work");

  // Sites are never removed from the mismatch table.
  a_table_grows: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> (tfill_r >= $past(tfill_r)))
    else $error("mismatch table fill decreased");

  // The stack fill count never exceeds the stack depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.req_type == ssrc_pkg::REQ_CALL)
      |=> (32'(fill_r) <= 32'(STACK_DEPTH)))
    else $error("stack fill count beyond depth");
`endif

endmodule

// ===== tb/ssrc_result_checker.sv =====
// Result checker for the shadow stack return checker: watches both channels,
// keeps its own copy of the stack and site table, and compares every result beat.
// Depends on ssrc_pkg for the beat types and request codes.
`timescale 1ns / 1ps

module ssrc_result_checker #(
  parameter int STACK_DEPTH   = 64,
  parameter int SEARCH_DEPTH  = 4,
  parameter int TABLE_ENTRIES = 64,
  parameter int COUNT_WIDTH   = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  ssrc_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  ssrc_pkg::out_t out_data,
  output int             error_count,
  output int             pending,
  output int             hit_count,
  output int             miss_count,
  output int             full_count,
  output int             overflow_count
);

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int TAW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [ssrc_pkg::SITE_W-1:0] stack_mem [STACK_DEPTH];
  logic [ssrc_pkg::SITE_W-1:0] tag_mem   [TABLE_ENTRIES];
  logic [COUNT_WIDTH-1:0]      count_mem [TABLE_ENTRIES];
  int unsigned                 top_ptr;
  int unsigned                 stack_fill;
  int unsigned                 table_fill;
  ssrc_pkg::out_t              pending_results [$];

  function automatic ssrc_pkg::out_t step_shadow_stack(ssrc_pkg::in_t beat);
    ssrc_pkg::out_t res;
    int unsigned    depth_lim;
    int unsigned    slot;
    bit             done;
    res  = '0;
    done = 1'b0;
    case (beat.req_type)
      ssrc_pkg::REQ_CALL: begin
        // A full stack wraps: the push lands on the oldest slot.
        if (stack_fill >= STACK_DEPTH) res.stack_overflowed = 1'b1;
        else stack_fill++;
        stack_mem[SAW'(top_ptr)] = beat.site_address;
        top_ptr = (top_ptr + 1) % STACK_DEPTH;
      end
      ssrc_pkg::REQ_RET: begin
        if (stack_fill == 0) begin
          res.stack_was_empty = 1'b1;
        end else begin
          depth_lim = (stack_fill < SEARCH_DEPTH) ? stack_fill : SEARCH_DEPTH;
          for (int i = 0; i < depth_lim && !done; i++) begin
            slot = (top_ptr + 2 * STACK_DEPTH - 1 - i) % STACK_DEPTH;
            if (stack_mem[SAW'(slot)] == beat.return_target) begin
              res.return_matched = 1'b1;
              res.match_depth    = 2'(i);
              stack_fill        -= i + 1;
              top_ptr            = (top_ptr + STACK_DEPTH - (i + 1)) % STACK_DEPTH;
              done               = 1'b1;
            end
          end
          if (!done) begin
            res.mismatch_flagged = 1'b1;
            res.report_site      = beat.site_address;
            for (int j = 0; j < table_fill && !done; j++) begin
              if (tag_mem[TAW'(j)] == beat.site_address) begin
                if (count_mem[TAW'(j)] != '1) count_mem[TAW'(j)]++;
                res.site_count = ssrc_pkg::OCNT_W'(count_mem[TAW'(j)]);
                done = 1'b1;
              end
            end
            if (!done) begin
              if (table_fill < TABLE_ENTRIES) begin
                tag_mem[TAW'(table_fill)]   = beat.site_address;
                count_mem[TAW'(table_fill)] = COUNT_WIDTH'(1);
                table_fill++;
                res.site_count = ssrc_pkg::OCNT_W'(1);
              end else begin
                res.table_full = 1'b1;
              end
            end
          end
        end
      end
      ssrc_pkg::REQ_READ: begin
        if (beat.entry_index < table_fill) begin
          res.entry_valid = 1'b1;
          res.report_site = tag_mem[TAW'(beat.entry_index)];
          res.site_count  = ssrc_pkg::OCNT_W'(count_mem[TAW'(beat.entry_index)]);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  task automatic compare_result(input ssrc_pkg::out_t want, input ssrc_pkg::out_t got);
    check_field("return_matched", want.return_matched, got.return_matched);
    check_field("match_depth", want.match_depth, got.match_depth);
    check_field("stack_was_empty", want.stack_was_empty, got.stack_was_empty);
    check_field("mismatch_flagged", want.mismatch_flagged, got.mismatch_flagged);
    check_field("report_site", want.report_site, got.report_site);
    check_field("site_count", want.site_count, got.site_count);
    check_field("entry_valid", want.entry_valid, got.entry_valid);
    check_field("table_full", want.table_full, got.table_full);
    check_field("stack_overflowed", want.stack_overflowed, got.stack_overflowed);
  endtask

  always @(posedge clk) begin
    ssrc_pkg::out_t want;
    if (!rst_n) begin
      top_ptr    = 0;
      stack_fill = 0;
      table_fill = 0;
      pending_results.delete();
    end else begin
      // Retire first: a beat accepted at this edge cannot have its result here.
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          error_count++;
          $display("%0t: result beat with nothing expected, expected none, got %h",
                   $time, out_data);
        end else begin
          want = pending_results.pop_front();
          compare_result(want, out_data);
        end
      end
      if (in_valid && in_ready) begin
        want = step_shadow_stack(in_data);
        hit_count      += want.return_matched;
        miss_count     += want.mismatch_flagged;
        full_count     += want.table_full;
        overflow_count += want.stack_overflowed;
        pending_results.push_back(want);
      end
    end
    pending = pending_results.size();
  end

endmodule

// ===== tb/shadow_stack_return_checker_top_tb.sv =====
// Testbench top for the shadow stack return checker: clock, reset, request and
// result pacing, and the verdict. Depends on ssrc_pkg, the block and ssrc_result_checker.
`timescale 1ns / 1ps

module shadow_stack_return_checker_top_tb;

  localparam int STACK_DEPTH = 64;
  localparam int POOL_SITES  = 72;
  localparam int POOL_AW     = $clog2(POOL_SITES);
  localparam int CYCLE_LIMIT = 2_000_000;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           out_ready = 1'b0;
  ssrc_pkg::in_t  in_data   = '0;
  logic           in_ready;
  logic           out_valid;
  ssrc_pkg::out_t out_data;

  int error_count, pending, hit_count, miss_count, full_count, overflow_count;
  int items_sent     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_token     = 0;
  int hold_taken     = 0;
  int hold_left      = 0;
  int cycle_count    = 0;

  logic [ssrc_pkg::SITE_W-1:0] site_pool [POOL_SITES];
  logic [ssrc_pkg::SITE_W-1:0] call_trail [$];

  shadow_stack_return_checker_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  ssrc_result_checker result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .error_count    (error_count),
    .pending        (pending),
    .hit_count      (hit_count),
    .miss_count     (miss_count),
    .full_count     (full_count),
    .overflow_count (overflow_count)
  );

  always #5 clk = ~clk;

  // Result side: random stalls, or a long hold-off when the stimulus asks for one.
  always @(posedge clk) begin
    if (hold_token != hold_taken) begin
      hold_taken = hold_token;
      hold_left  = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count, pending);
      $display("** shadow_stack_return_checker_top: FAILED **");
      $finish;
    end
  end

  function automatic logic [ssrc_pkg::SITE_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ssrc_pkg::SITE_W-1:0] pick_site();
    if ($urandom_range(0, 99) < 85)
      return site_pool[POOL_AW'($urandom_range(0, POOL_SITES - 1))];
    return rand64();
  endfunction

  // Unused fields carry random bits so that every input bit toggles.
  function automatic ssrc_pkg::in_t fresh_beat(logic [1:0] req);
    ssrc_pkg::in_t b;
    b.req_type      = req;
    b.site_address  = rand64();
    b.return_target = rand64();
    b.entry_index   = ssrc_pkg::INDEX_W'($urandom_range(0, 63));
    return b;
  endfunction

  task automatic send_beat(input ssrc_pkg::in_t beat);
    int gap;
    in_data  <= beat;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    gap = 0;
    while (gap < 30 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_call(input logic [ssrc_pkg::SITE_W-1:0] addr);
    ssrc_pkg::in_t b;
    b = fresh_beat(ssrc_pkg::REQ_CALL);
    b.site_address = addr;
    call_trail.push_back(addr);
    if (call_trail.size() > STACK_DEPTH) void'(call_trail.pop_front());
    send_beat(b);
  endtask

  // The call trail mirrors the stack closely enough to aim returns at live entries.
  task automatic send_ret(input logic [ssrc_pkg::SITE_W-1:0] site,
                          input logic [ssrc_pkg::SITE_W-1:0] target);
    ssrc_pkg::in_t b;
    int            lim;
    b = fresh_beat(ssrc_pkg::REQ_RET);
    b.site_address  = site;
    b.return_target = target;
    lim = (call_trail.size() < 4) ? call_trail.size() : 4;
    for (int i = 0; i < lim; i++) begin
      if (call_trail[call_trail.size() - 1 - i] == target) begin
        repeat (i + 1) void'(call_trail.pop_back());
        break;
      end
    end
    send_beat(b);
  endtask

  task automatic send_read(input logic [ssrc_pkg::INDEX_W-1:0] idx);
    ssrc_pkg::in_t b;
    b = fresh_beat(ssrc_pkg::REQ_READ);
    b.entry_index = idx;
    send_beat(b);
  endtask

  task automatic random_item();
    int pick, lim, k;
    pick = $urandom_range(0, 99);
    if (pick < 44) begin
      send_call(rand64());
    end else if (pick < 68) begin
      if (call_trail.size() == 0) begin
        send_ret(pick_site(), rand64());
      end else begin
        lim = (call_trail.size() < 4) ? call_trail.size() : 4;
        k = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, lim - 1);
        send_ret(pick_site(), call_trail[call_trail.size() - 1 - k]);
      end
    end else if (pick < 84) begin
      send_ret(pick_site(), rand64());
    end else if (pick < 97) begin
      send_read(ssrc_pkg::INDEX_W'($urandom_range(0, 63)));
    end else begin
      send_beat(fresh_beat(ssrc_pkg::REQ_NONE));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    ssrc_pkg::in_t all_ones;
    foreach (site_pool[i]) site_pool[i] = rand64();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty stack and table, idle request, hits at several depths,
    // repeated and new mismatch sites, reads, and a target just below the search window.
    send_ret('0, '0);
    send_read('0);
    send_read('1);
    all_ones = '1;
    send_beat(all_ones);
    send_call('1);
    send_call('0);
    send_call(64'h0123_4567_89ab_cdef);
    send_call(64'hfedc_ba98_7654_3210);
    send_call(64'h5555_5555_5555_5555);
    send_ret('1, 64'h5555_5555_5555_5555);
    send_ret('0, '1);
    send_call(64'haaaa_aaaa_aaaa_aaaa);
    send_call(64'h8000_0000_0000_0001);
    send_ret('1, 64'h123);
    send_ret('1, 64'h456);
    send_ret('0, '0);
    send_ret(64'h0123_4567_89ab_cdef, 64'haaaa_aaaa_aaaa_aaaa);
    send_read(ssrc_pkg::INDEX_W'(0));
    send_read(ssrc_pkg::INDEX_W'(1));
    send_read(ssrc_pkg::INDEX_W'(2));
    for (int i = 1; i <= 5; i++) send_call(64'h1000 + i);
    send_ret(64'hfedc_ba98_7654_3210, 64'h1001);
    wait_drained();

    // No idling, with a long result hold-off at the start and a deep call burst
    // that wraps the stack.
    hold_token++;
    repeat (150) random_item();
    repeat (70) send_call(rand64());
    repeat (200) random_item();
    wait_drained();

    send_idle_pct = 72;
    repeat (410) random_item();
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 72;
    repeat (410) random_item();
    wait_drained();

    send_idle_pct  = 16;
    recv_stall_pct = 16;
    repeat (390) random_item();
    wait_drained();
    repeat (150) @(posedge clk);

    $display("Run covered %0d request beats over four pacing mixes and a long result hold-off.",
             items_sent);
    $display("Seen: %0d return hits, %0d counted mismatches, %0d full-table rejects, %0d overflows.",
             hit_count, miss_count, full_count, overflow_count);
    if (pending != 0) $display("%0d expected results never arrived.", pending);
    if (error_count == 0 && pending == 0) begin
      $display("** shadow_stack_return_checker_top: PASSED **");
    end else begin
      $display("** shadow_stack_return_checker_top: FAILED **");
    end
    $finish;
  end

endmodule
